// ===== rtl/core/axs_pkg.sv =====
package axs_pkg;

   // field widths
   localparam int WordW   = 32;
   localparam int AddrW   = 64;
   localparam int RegCnt  = 32;
   localparam int RegIdxW = $clog2(RegCnt);

   // result tuser bit positions
   localparam int RspHitBit      = 0;
   localparam int RspNotFoundBit = 1;
   localparam int RspUserW       = 2;

   // opcode masks and match values
   localparam logic [31:0] AdrpMask  = 32'h9F00_0000;
   localparam logic [31:0] AdrpMatch = 32'h9000_0000;
   localparam logic [31:0] AddMask   = 32'hFF00_0000;
   localparam logic [31:0] AddMatch  = 32'h9100_0000;
   localparam logic [31:0] LdrMask   = 32'hF9C0_0000;
   localparam logic [31:0] LdrMatch  = 32'hF940_0000;
   localparam logic [31:0] AdrMask   = 32'h9F00_0000;
   localparam logic [31:0] AdrMatch  = 32'h1000_0000;
   localparam logic [31:0] LdrlMask  = 32'hFF00_0000;
   localparam logic [31:0] LdrlMatch = 32'h5800_0000;
   localparam logic [63:0] PageMask  = 64'h0000_0000_0000_0FFF;

   // one input word as held in the input register
   typedef struct packed {
      logic [WordW-1:0] word;
      logic [AddrW-1:0] addr;
      logic             first;
      logic             last;
   } item_type;

endpackage

// ===== rtl/core/arm64_address_xref_scanner.sv =====
// an accepted req word passes the input register, then the result register, to become its rsp word
// throughput: one word per cycle while the rsp side is not stalled; the register table is a 32x64
//    memory with two registered read ports and one write port, with a one-deep bypass from the word ahead
// reset: synchronous, active high; clears valid flags, the found flag, target_value and the
//    table valid bits, so every table entry reads as zero; table memory itself is not cleared
module arm64_address_xref_scanner
   import axs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration: target_value
   input  logic                csr_we,
   input  logic [AddrW-1:0]    csr_wdata,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [95:0]         req_tdata,   // instr_word [31:0], instr_addr [95:32]
   input  logic                req_tuser,   // first
   input  logic                req_tlast,   // last
   // response channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [AddrW-1:0]    rsp_tdata,   // hit_addr [63:0]
   output logic [RspUserW-1:0] rsp_tuser    // hit [0], not_found [1]
);

   // control registers
   logic                s1_valid_ff;
   logic                rsp_valid_ff;
   logic                found_ff;
   logic                found_in;
   logic [RegCnt-1:0]   valid_ff;
   logic [RegCnt-1:0]   valid_in;
   logic [AddrW-1:0]    target_ff;

   // payload registers
   item_type            s1_ff;
   logic [AddrW-1:0]    rd_n_ff;
   logic [AddrW-1:0]    rd_d_ff;
   logic                fwd_n_ff;
   logic                fwd_d_ff;
   logic                val_n_ff;
   logic                val_d_ff;
   logic [AddrW-1:0]    fwd_data_ff;
   logic [AddrW-1:0]    rsp_data_ff;
   logic [RspUserW-1:0] rsp_user_ff;
   logic [AddrW-1:0]    mem [RegCnt];

   // handshake
   logic                s1_move;
   logic                req_accept;
   logic [RegIdxW-1:0]  new_n;
   logic [RegIdxW-1:0]  new_d;

   // decode and datapath
   logic [WordW-1:0]    w;
   logic [AddrW-1:0]    a;
   logic [RegIdxW-1:0]  d;
   logic [11:0]         imm12;
   logic [20:0]         imm21;
   logic [AddrW-1:0]    opn;
   logic [AddrW-1:0]    opd;
   logic [AddrW-1:0]    base;
   logic [AddrW-1:0]    ofs;
   logic [AddrW-1:0]    wval;
   logic [AddrW-1:0]    cmp_val;
   logic                we;
   logic                cmp;
   logic                found_cur;
   logic                hit;
   logic                not_found;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;
   assign new_d      = req_tdata[RegIdxW-1:0];
   assign new_n      = req_tdata[2*RegIdxW-1:RegIdxW];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // field extraction
   assign w     = s1_ff.word;
   assign a     = {s1_ff.addr[AddrW-1:2], 2'b00};
   assign d     = w[RegIdxW-1:0];
   assign imm12 = w[21:10];
   assign imm21 = {w[23:5], w[30:29]};

   // source operands: a new scan reads zero, else bypass, else memory if entry valid
   always_comb begin
      opn = '0;
      opd = '0;
      if (!s1_ff.first) begin
         if (fwd_n_ff) begin
            opn = fwd_data_ff;
         end else if (val_n_ff) begin
            opn = rd_n_ff;
         end
         if (fwd_d_ff) begin
            opd = fwd_data_ff;
         end else if (val_d_ff) begin
            opd = rd_d_ff;
         end
      end
   end

   // instruction decode, picks the adder operands
   always_comb begin
      base = '0;
      ofs  = '0;
      we   = 1'b0;
      cmp  = 1'b1;
      if ((w & AdrpMask) == AdrpMatch) begin
         base = a & ~PageMask;
         ofs  = {{31{imm21[20]}}, imm21, 12'h000};
         we   = 1'b1;
         cmp  = 1'b0;
      end else if ((w & AddMask) == AddMatch) begin
         // shift codes 2 and 3 are skipped entirely
         if (w[23]) begin
            cmp = 1'b0;
         end else begin
            base = opn;
            ofs  = w[22] ? {40'h0, imm12, 12'h000} : {52'h0, imm12};
            we   = 1'b1;
         end
      end else if ((w & LdrMask) == LdrMatch) begin
         // zero offset load is skipped
         if (imm12 == 12'h000) begin
            cmp = 1'b0;
         end else begin
            base = opn;
            ofs  = {49'h0, imm12, 3'b000};
            we   = 1'b1;
         end
      end else if ((w & AdrMask) == AdrMatch) begin
         base = a;
         ofs  = {{43{imm21[20]}}, imm21};
         we   = 1'b1;
      end else if ((w & LdrlMask) == LdrlMatch) begin
         base = a;
         ofs  = {43'h0, w[23:5], 2'b00};
         we   = 1'b1;
      end
   end

   assign wval    = base + ofs;
   assign cmp_val = we ? wval : opd;

   // match detection
   assign found_cur = s1_ff.first ? 1'b0 : found_ff;
   assign hit       = cmp && !found_cur && (cmp_val == target_ff);
   assign found_in  = s1_move ? (found_cur | hit) : found_ff;
   assign not_found = s1_ff.last && !(found_cur | hit);

   // table valid bits after the word in the input register retires
   always_comb begin
      valid_in = valid_ff;
      if (s1_move) begin
         if (s1_ff.first) begin
            valid_in = '0;
         end
         if (we) begin
            valid_in[d] = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         valid_ff     <= '0;
         target_ff    <= '0;
      end else begin
         if (csr_we) begin
            target_ff <= csr_wdata;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         found_ff <= found_in;
         valid_ff <= valid_in;
      end
   end

   // input register, table reads with bypass capture, result register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff.word  <= req_tdata[WordW-1:0];
         s1_ff.addr  <= req_tdata[WordW+AddrW-1:WordW];
         s1_ff.first <= req_tuser;
         s1_ff.last  <= req_tlast;
         rd_n_ff     <= mem[new_n];
         rd_d_ff     <= mem[new_d];
         fwd_n_ff    <= s1_move && we && (d == new_n);
         fwd_d_ff    <= s1_move && we && (d == new_d);
         val_n_ff    <= valid_in[new_n];
         val_d_ff    <= valid_in[new_d];
         fwd_data_ff <= wval;
      end
      if (s1_move) begin
         rsp_data_ff                 <= hit ? a : '0;
         rsp_user_ff[RspHitBit]      <= hit;
         rsp_user_ff[RspNotFoundBit] <= not_found;
      end
      if (s1_move && we) begin
         mem[d] <= wval;
      end
   end

endmodule

// ===== rtl/core/axs_checker.sv =====
module axs_checker
   import axs_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [AddrW-1:0]    rsp_tdata,
   input logic [RspUserW-1:0] rsp_tuser
);

   // reset leaves no word on the response side
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word valid right after reset");

   // a hit address is word aligned
   a_hit_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RspHitBit] |-> rsp_tdata[1:0] == 2'b00)
      else $error("hit address not aligned");

   // no hit means a zero address
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RspHitBit] |-> rsp_tdata == '0)
      else $error("address on a word without hit");

   // a hit word never says not found
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RspHitBit] |-> !rsp_tuser[RspNotFoundBit])
      else $error("hit and not_found together");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

endmodule

bind arm64_address_xref_scanner axs_checker u_axs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/arm64_address_xref_scanner_tb.sv =====
module arm64_address_xref_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import axs_pkg::*;

   localparam int MaxReports  = 40;
   localparam int RandomWords = 1300;
   localparam int PhaseCount  = 8;

   // one expected rsp word
   typedef struct packed {
      logic             hit;
      logic [AddrW-1:0] hit_addr;
      logic             not_found;
   } scan_result_type;

   // one instruction word with its address
   typedef struct packed {
      logic [WordW-1:0] word;
      logic [AddrW-1:0] addr;
   } code_word_type;

   typedef enum int {
      KindAdrp, KindAdd, KindAddSkip, KindLdr, KindLdrZero, KindAdr, KindLdrl, KindRaw
   } instr_kind_type;

   typedef enum int {
      ChainAdrpAdd, ChainAdrpLdr, ChainAdr, ChainLdrl
   } chain_kind_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_we     = 1'b0;
   logic [AddrW-1:0]    csr_wdata  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [95:0]         req_tdata  = '0;   // instr_word [31:0], instr_addr [95:32]
   logic                req_tuser  = 1'b0; // first
   logic                req_tlast  = 1'b0; // last
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [AddrW-1:0]    rsp_tdata;         // hit_addr [63:0]
   logic [RspUserW-1:0] rsp_tuser;         // hit [0], not_found [1]

   // scanner state as predicted
   logic [AddrW-1:0] xref_regs [RegCnt];
   bit               xref_found;
   logic [AddrW-1:0] xref_target;

   scan_result_type expected_q[$];
   code_word_type   scan_words[$];
   int              error_count = 0;
   int              words_sent  = 0;
   int              rsp_hold    = 0;
   bit              no_gaps     = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   arm64_address_xref_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic logic [63:0] sext21(logic [20:0] v);
      return {{43{v[20]}}, v};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // table update and compare for one word
   function automatic scan_result_type predict_xref(logic [31:0] w, logic [63:0] raw_addr,
                                                    logic f, logic l);
      logic [63:0]     a;
      logic [4:0]      d;
      logic [4:0]      n;
      logic [63:0]     imm12;
      bit              compare;
      scan_result_type r;
      a       = {raw_addr[63:2], 2'b00};
      d       = w[4:0];
      n       = w[9:5];
      imm12   = {52'd0, w[21:10]};
      compare = 1'b1;
      r       = '0;
      if (f) begin
         foreach (xref_regs[i]) xref_regs[i] = '0;
         xref_found = 1'b0;
      end
      if ((w & AdrpMask) == AdrpMatch) begin
         xref_regs[d] = (a & ~PageMask) + (sext21({w[23:5], w[30:29]}) << 12);
         compare      = 1'b0;
      end else if ((w & AddMask) == AddMatch) begin
         // shift 2 and 3 are skipped
         if (w[23])
            compare = 1'b0;
         else
            xref_regs[d] = xref_regs[n] + (w[22] ? (imm12 << 12) : imm12);
      end else if ((w & LdrMask) == LdrMatch) begin
         if (w[21:10] == 12'd0)
            compare = 1'b0;
         else
            xref_regs[d] = xref_regs[n] + (imm12 << 3);
      end else if ((w & AdrMask) == AdrMatch) begin
         xref_regs[d] = a + sext21({w[23:5], w[30:29]});
      end else if ((w & LdrlMask) == LdrlMatch) begin
         xref_regs[d] = a + {43'd0, w[23:5], 2'b00};
      end
      if (compare && !xref_found && xref_regs[d] == xref_target) begin
         r.hit      = 1'b1;
         r.hit_addr = a;
         xref_found = 1'b1;
      end
      r.not_found = l && !xref_found;
      return r;
   endfunction

   // instruction encoders
   function automatic logic [31:0] enc_pc_rel(logic [31:0] op, logic [4:0] d, logic [20:0] imm);
      return op | {1'b0, imm[1:0], 5'b0, imm[20:2], d};
   endfunction

   function automatic logic [31:0] enc_add(logic [4:0] d, logic [4:0] n, logic [11:0] imm,
                                           logic [1:0] sh);
      return AddMatch | {8'b0, sh, imm, n, d};
   endfunction

   function automatic logic [31:0] enc_ldr(logic [4:0] d, logic [4:0] n, logic [11:0] imm);
      return LdrMatch | {10'b0, imm, n, d};
   endfunction

   function automatic logic [31:0] enc_ldrl(logic [4:0] d, logic [18:0] imm);
      return LdrlMatch | {8'b0, imm, d};
   endfunction

   // low registers half the time so that words depend on each other
   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 3)) : 5'($urandom);
   endfunction

   function automatic logic [31:0] rand_instr();
      instr_kind_type k;
      int             r;
      logic [4:0]     d;
      logic [4:0]     n;
      r = $urandom_range(0, 8);
      k = (r >= KindRaw) ? KindRaw : instr_kind_type'(r);
      d = pick_reg();
      n = pick_reg();
      case (k)
         KindAdrp:    return enc_pc_rel(AdrpMatch, d, 21'($urandom));
         KindAdd:     return enc_add(d, n, 12'($urandom), {1'b0, 1'($urandom)});
         KindAddSkip: return enc_add(d, n, 12'($urandom), {1'b1, 1'($urandom)});
         KindLdr:     return enc_ldr(d, n, 12'($urandom));
         KindLdrZero: return enc_ldr(d, n, 12'd0);
         KindAdr:     return enc_pc_rel(AdrMatch, d, 21'($urandom));
         KindLdrl:    return enc_ldrl(d, 19'($urandom));
         default:     return $urandom;
      endcase
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < MaxReports)
         $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // send one req word and record what it should produce
   task automatic send_word(logic [31:0] w, logic [63:0] a, logic f, logic l);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {a, w};
      req_tuser  <= f;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(predict_xref(w, a, f, l));
      words_sent++;
   endtask

   // hold off until every rsp word is back and the pipeline is empty
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_target(logic [63:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we      <= 1'b0;
      xref_target = v;
   endtask

   // insert a short sequence that computes the target address
   task automatic add_xref_chain(int pos);
      chain_kind_type k;
      logic [4:0]     d;
      logic [4:0]     n;
      logic [20:0]    delta;
      logic [20:0]    imm21;
      logic [18:0]    imm19;
      logic [11:0]    off;
      logic [63:0]    page;
      logic [63:0]    a;
      code_word_type  c[$];
      k = chain_kind_type'($urandom_range(0, ChainLdrl));
      if (k == ChainAdrpLdr && xref_target[2:0] != 3'd0) k = ChainAdrpAdd;
      d     = pick_reg();
      n     = pick_reg();
      delta = 21'($urandom);
      case (k)
         ChainAdrpAdd: begin
            page     = xref_target & ~PageMask;
            a        = page - (sext21(delta) << 12);
            a[11:0]  = 12'($urandom);
            c.push_back('{enc_pc_rel(AdrpMatch, n, delta), a});
            c.push_back('{enc_add(d, n, xref_target[11:0], 2'b00), a + 64'd4});
         end
         ChainAdrpLdr: begin
            off = {3'($urandom), xref_target[11:3]};
            if (off == 12'd0) off = 12'h200;
            page     = xref_target - {49'd0, off, 3'b000};
            a        = page - (sext21(delta) << 12);
            a[11:0]  = 12'($urandom);
            c.push_back('{enc_pc_rel(AdrpMatch, n, delta), a});
            c.push_back('{enc_ldr(d, n, off), a + 64'd4});
         end
         ChainAdr: begin
            imm21  = {19'($urandom), xref_target[1:0]};
            a      = xref_target - sext21(imm21);
            a[1:0] = 2'($urandom);
            c.push_back('{enc_pc_rel(AdrMatch, d, imm21), a});
         end
         default: begin
            imm19  = 19'($urandom);
            a      = xref_target - {43'd0, imm19, 2'b00};
            a[1:0] = 2'($urandom);
            c.push_back('{enc_ldrl(d, imm19), a});
         end
      endcase
      foreach (c[i]) scan_words.insert(pos + i, c[i]);
   endtask

   // one scan range: random words, often with a cross reference inside
   task automatic run_scan();
      int          len;
      bit          broken;
      logic        f;
      logic        l;
      logic [63:0] pc;
      scan_words.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      pc  = rand64();
      for (int i = 0; i < len; i++) begin
         scan_words.push_back('{rand_instr(), pc});
         pc += 64'd4;
      end
      if ($urandom_range(0, 3) != 0) add_xref_chain($urandom_range(0, scan_words.size()));
      broken = ($urandom_range(0, 9) == 0);
      foreach (scan_words[i]) begin
         f = (i == 0);
         l = (i == scan_words.size() - 1);
         if (broken) begin
            f = ($urandom_range(0, 3) == 0);
            l = ($urandom_range(0, 3) == 0);
         end
         send_word(scan_words[i].word, scan_words[i].addr, f, l);
      end
      // words past the end of the range with no new start
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 4))
            send_word(rand_instr(), rand64(), 1'b0, 1'($urandom_range(0, 1)));
   endtask

   // no first word: scan runs from the reset table, target at reset value
   task automatic test_reset_state();
      send_word(32'hD503_201F, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
      send_word(enc_add(5'd3, 5'd31, 12'd0, 2'b00), 64'h4, 1'b0, 1'b1);
   endtask

   // every opcode, both skip cases, extremes of the immediates, repeated match
   task automatic test_opcodes();
      wait_all_results();
      write_target(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(enc_pc_rel(AdrpMatch, 5'd1, 21'h10_0000), 64'h0, 1'b1, 1'b0);
      send_word(enc_add(5'd2, 5'd1, 12'hFFF, 2'b01), 64'h4, 1'b0, 1'b0);
      send_word(enc_add(5'd4, 5'd1, 12'h005, 2'b10), 64'h8, 1'b0, 1'b0);
      send_word(enc_add(5'd4, 5'd1, 12'h005, 2'b11), 64'hC, 1'b0, 1'b0);
      send_word(enc_ldr(5'd5, 5'd1, 12'h000), 64'h10, 1'b0, 1'b0);
      send_word(enc_ldr(5'd5, 5'd2, 12'hFFF), 64'h14, 1'b0, 1'b0);
      send_word(enc_ldrl(5'd6, 19'h7_FFFF), 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
      send_word(32'h0000_0000, 64'h1C, 1'b0, 1'b0);
      send_word(enc_pc_rel(AdrMatch, 5'd8, 21'h1F_FFFF), 64'h3, 1'b0, 1'b0);
      send_word(enc_pc_rel(AdrMatch, 5'd9, 21'h1F_FFFF), 64'h0, 1'b0, 1'b0);
      send_word(enc_pc_rel(AdrpMatch, 5'd10, 21'h0F_FFFF), 64'hFFFF_FFFF_FFFF_F000,
                1'b0, 1'b1);
   endtask

   // scan range that ends with no match
   task automatic test_no_match_scan();
      send_word(32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFC, 1'b1, 1'b0);
      send_word(enc_pc_rel(AdrMatch, 5'd7, 21'h0F_FFFF), 64'h8000_0000_0000_0000, 1'b0, 1'b1);
   endtask

   // words after last without first keep the state, last reports again
   task automatic test_resumed_scan();
      wait_all_results();
      write_target(64'h0);
      send_word(enc_add(5'd2, 5'd2, 12'h001, 2'b00), 64'h100, 1'b1, 1'b1);
      send_word(enc_pc_rel(AdrpMatch, 5'd0, 21'h00_0001), 64'h104, 1'b0, 1'b1);
      send_word(32'hD503_201F, 64'h108, 1'b0, 1'b0);
      send_word(enc_ldrl(5'd3, 19'h0), 64'h10C, 1'b0, 1'b1);
   endtask

   // random scans over several target settings
   task automatic test_random_scans();
      int          phase_end;
      logic [63:0] tgt;
      for (int p = 0; p < PhaseCount; p++) begin
         wait_all_results();
         no_gaps = 1'b0;
         case (p % 6)
            0:       tgt = rand64();
            1:       tgt = 64'hFFFF_FFFF_FFFF_FFFF;
            2:       tgt = 64'h0;
            3:       tgt = rand64() & ~64'h7;
            4:       tgt = 64'($urandom_range(0, 16'hFFFF));
            default: tgt = rand64() & ~64'h3;
         endcase
         write_target(tgt);
         phase_end = words_sent + RandomWords / PhaseCount;
         while (words_sent < phase_end) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            run_scan();
            if ($urandom_range(0, 24) == 0) wait_all_results();
         end
      end
      no_gaps = 1'b0;
   endtask

   // rsp side stalls
   always @(posedge clock) begin : rsp_stall
      int gap;
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= gap - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each rsp word with the oldest expected one
   always @(posedge clock) begin : rsp_check
      scan_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("rsp word with none expected, tdata %h tuser %b",
                                      rsp_tdata, rsp_tuser));
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_tuser[RspHitBit] !== exp_r.hit)
               report_mismatch($sformatf("hit %b, expected %b",
                                         rsp_tuser[RspHitBit], exp_r.hit));
            if (rsp_tdata !== exp_r.hit_addr)
               report_mismatch($sformatf("hit_addr %h, expected %h",
                                         rsp_tdata, exp_r.hit_addr));
            if (rsp_tuser[RspNotFoundBit] !== exp_r.not_found)
               report_mismatch($sformatf("not_found %b, expected %b",
                                         rsp_tuser[RspNotFoundBit], exp_r.not_found));
         end
      end
   end

   initial begin
      foreach (xref_regs[i]) xref_regs[i] = '0;
      xref_found  = 1'b0;
      xref_target = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_opcodes();
      test_no_match_scan();
      test_resumed_scan();
      test_random_scans();
      wait_all_results();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // run limit
   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/axs_pkg.sv
rtl/core/arm64_address_xref_scanner.sv
rtl/core/axs_checker.sv
sim/arm64_address_xref_scanner_tb.sv
